// ===== rtl/dpec_pkg.sv =====
package dpec_pkg;

  localparam int unsigned NumDiscs = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned PartW = 5;
  localparam logic [PartW-1:0] NoPartner = 5'd31;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegContact = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFriction = 1'b1;

  localparam int unsigned InDataW = 168;
  localparam int unsigned OutDataW = 80;

  // widths of the working values
  localparam int unsigned DW = 21;    // position difference
  localparam int unsigned D2W = 42;   // squared distance
  localparam int unsigned NumW = 44;  // projection numerator
  localparam int unsigned ProdW = 65; // numerator times difference

  // datapath commands from the controller
  typedef struct packed {
    logic load;        // capture the input item
    logic mul_step;    // advance the multiply sequence
    logic div_start;   // start a long division
    logic div_step;    // one quotient bit
    logic div_take;    // store the finished quotient
    logic [2:0] sel;   // which step or division
    logic finish;      // build the result
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic skip;        // no collision work needed
    logic coincident;  // centres coincide
    logic div_done;    // division finished
  } dp_sts_t;

endpackage

// ===== rtl/disc_pair_elastic_collision.sv =====
// channel | dir | fields (low bit up)
// s_axis  | in  | index_first, index_second, first/second pos x,z, vel x,z; tuser both_active
// m_axis  | out | out_first_vel_x/z, out_second_vel_x/z; tuser collided, repeat_skipped
// cfg     | in  | 0 contact_distance, 1 friction_divisor
// One item at a time. A contact pair runs six multiply steps, then six 65-bit
// bit-serial divisions, before its result is valid.
// Coincident centres need four divisions; repeat or inactive pairs skip after the
// repeat test, pairs out of reach after the reach test. Reset clears the partner table.
// Output register holds the result until taken; input waits while busy.
module disc_pair_elastic_collision (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,  // idx1,idx2,p1x,p1z,p2x,p2z,v1x,v1z,v2x,v2z
  input  logic         s_axis_tuser,  // both_active
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // v1x,v1z,v2x,v2z
  output logic [1:0]   m_axis_tuser,  // collided, repeat_skipped
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  dpec_pkg::dp_cmd_t cmd;
  dpec_pkg::dp_sts_t sts;
  logic busy, out_load, in_fire, oob, col, rep;
  logic [79:0] vel;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  // out-of-range indices cannot occur with 16 discs on 4 bits
  assign oob = 1'b0;

  dpec_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_free_i(!m_axis_tvalid || m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .out_load_o(out_load)
  );

  dpec_dp u_dp (
    .clk_i, .rst_ni, .in_data_i(s_axis_tdata), .both_active_i(s_axis_tuser || oob),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cmd_i(cmd), .sts_o(sts),
    .collided_o(col), .repeat_o(rep), .vel_o(vel)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= vel;
      m_axis_tuser <= {rep, col};
    end
  end

endmodule

// ===== rtl/dpec_ctrl.sv =====
module dpec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              out_free_i,
  input  dpec_pkg::dp_sts_t sts_i,
  output dpec_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              out_load_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIVS = 7'b0000100,
    S_DIVR = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_SKIP = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] sel_q, sel_d;

  // step sequencer
  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    cmd_o = '0;
    cmd_o.sel = sel_q;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          sel_d = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // step 0 settles the repeat test, steps 1..5 build products;
        // skip is checked after the repeat test and after the reach test
        if ((sel_q == 3'd1 || sel_q == 3'd4) && sts_i.skip) begin
          state_d = S_SKIP;
        end else begin
          cmd_o.mul_step = 1'b1;
          if (sel_q == 3'd5) begin
            sel_d = sts_i.coincident ? 3'd2 : 3'd0;
            state_d = S_DIVS;
          end else begin
            sel_d = sel_q + 3'd1;
          end
        end
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVR;
      end
      S_DIVR: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          if (sel_q == 3'd5) begin
            state_d = S_FIN;
          end else begin
            sel_d = sel_q + 3'd1;
            state_d = S_DIVS;
          end
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_SKIP, S_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q <= '0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> state_q == S_IDLE) else $error("no return to idle");

endmodule

// ===== rtl/dpec_dp.sv =====
module dpec_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dpec_pkg::InDataW-1:0] in_data_i,
  input  logic                        both_active_i,
  input  logic                        cfg_we_i,
  input  logic [dpec_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dpec_pkg::CfgDataW-1:0] cfg_data_i,
  input  dpec_pkg::dp_cmd_t           cmd_i,
  output dpec_pkg::dp_sts_t           sts_o,
  output logic                        collided_o,
  output logic                        repeat_o,
  output logic [dpec_pkg::OutDataW-1:0] vel_o
);

  localparam int unsigned DW = dpec_pkg::DW;
  localparam int unsigned D2W = dpec_pkg::D2W;
  localparam int unsigned NumW = dpec_pkg::NumW;
  localparam int unsigned ProdW = dpec_pkg::ProdW;
  localparam int unsigned DivW = ProdW;
  localparam int unsigned CntW = 7;
  localparam logic signed [DivW:0] QMax = (DivW+1)'(4194303);
  localparam logic signed [DivW:0] QMin = (DivW+1)'(-4194304);

  // configuration registers
  logic [15:0] contact_q;
  logic [11:0] friction_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_q <= 16'd2560;
      friction_q <= 12'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpec_pkg::RegContact:  contact_q <= cfg_data_i;
        dpec_pkg::RegFriction: friction_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // partner table, reset to none
  logic [dpec_pkg::PartW-1:0] partner_q [dpec_pkg::NumDiscs];

  // captured item
  logic [3:0] u_q, v_q;
  logic signed [19:0] p1x_q, p1z_q, p2x_q, p2z_q;
  logic signed [19:0] v1x_q, v1z_q, v2x_q, v2z_q;
  logic act_q;

  logic signed [DW-1:0] dx_q, dz_q;
  logic [D2W-1:0] d2_q;
  logic signed [NumW-1:0] num_q;
  logic signed [ProdW-1:0] pa_q;
  logic skip_q, rep_q, coin_q;
  logic signed [22:0] n_q [4];

  // shared multiplier, 44x21
  logic signed [NumW-1:0] ma;
  logic signed [DW-1:0] mb;
  logic signed [ProdW-1:0] mp;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.sel)
      3'd0: begin ma = num_q; mb = dz_q; end
      3'd1: begin ma = NumW'(dx_q); mb = dx_q; end
      3'd2: begin ma = NumW'(dz_q); mb = dz_q; end
      3'd3: begin ma = NumW'(DW'(v2x_q) - DW'(v1x_q)); mb = dx_q; end
      3'd4: begin ma = NumW'(DW'(v2z_q) - DW'(v1z_q)); mb = dz_q; end
      3'd5: begin ma = num_q; mb = dx_q; end
      default: ;
    endcase
    mp = ma * mb;
  end

  // long division unit, restoring, one bit a cycle
  logic [DivW-1:0] dvd_q, rem_q;
  logic [DivW-1:0] dvs_q;
  logic neg_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW:0] trial;
  logic [DivW-1:0] div_num;
  logic [DivW-1:0] div_den;
  logic div_neg;
  logic [DivW-1:0] quo;
  logic signed [DivW:0] quo_s;

  // division operands per select
  logic signed [22:0] nsrc;
  logic [11:0] fdiv;
  always_comb begin
    fdiv = (friction_q < 12'd256) ? 12'd256 : friction_q;
    nsrc = n_q[cmd_i.sel[1:0] - 2'd2];
    if (cmd_i.sel[2:1] == 2'b00) begin
      // projection: num*d / d2
      div_neg = pa_q[ProdW-1] ^ 1'b0;
      div_num = pa_q[ProdW-1] ? DivW'(-pa_q) : DivW'(pa_q);
      div_den = DivW'(d2_q);
    end else begin
      div_neg = nsrc[22];
      div_num = nsrc[22] ? DivW'({-31'(nsrc), 8'd0}) : DivW'({31'(nsrc), 8'd0});
      div_den = DivW'(fdiv);
    end
  end

  assign trial = {rem_q, dvd_q[DivW-1]} - {1'b0, dvs_q};
  assign quo = dvd_q;
  assign quo_s = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= div_num;
      rem_q <= '0;
      dvs_q <= div_den;
      neg_q <= div_neg;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[DivW]) begin
        rem_q <= trial[DivW-1:0];
        dvd_q <= {dvd_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DivW-2:0], dvd_q[DivW-1]};
        dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      end
      cnt_q <= cnt_q + CntW'(1);
    end
  end
  assign sts_o.div_done = (cnt_q == CntW'(DivW));

  function automatic logic signed [22:0] sat_q(input logic signed [DivW:0] x);
    // clamp a quotient to the working range
    if (x > QMax) return 23'sd4194303;
    if (x < QMin) return -23'sd4194304;
    return 23'(x);
  endfunction

  function automatic logic [19:0] sat20(input logic signed [22:0] x);
    if (x > 23'sd524287) return 20'h7FFFF;
    if (x < -23'sd524288) return 20'h80000;
    return x[19:0];
  endfunction

  // main registers
  logic [4:0] pu, pv;
  always_comb begin
    pu = partner_q[u_q];
    pv = partner_q[v_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      {act_q, v2z_q, v2x_q, v1z_q, v1x_q, p2z_q, p2x_q, p1z_q, p1x_q, v_q, u_q} <=
        {both_active_i, in_data_i};
    end else if (cmd_i.mul_step) begin
      case (cmd_i.sel)
        3'd0: begin
          dx_q <= DW'(p2x_q) - DW'(p1x_q);
          dz_q <= DW'(p2z_q) - DW'(p1z_q);
          rep_q <= (pu == {1'b0, v_q}) && (pv == {1'b0, u_q});
          skip_q <= ((pu == {1'b0, v_q}) && (pv == {1'b0, u_q})) || !act_q;
        end
        3'd1: d2_q <= D2W'(mp);
        3'd2: begin
          d2_q <= d2_q + D2W'(mp);
          n_q[0] <= 23'(v2x_q); n_q[1] <= 23'(v1z_q);
          n_q[2] <= 23'(v1x_q); n_q[3] <= 23'(v2z_q);
        end
        3'd3: begin
          num_q <= NumW'(mp);
          skip_q <= d2_q > D2W'(32'(contact_q) * 32'(contact_q));
          coin_q <= (d2_q == '0);
        end
        3'd4: num_q <= num_q + NumW'(mp);
        default: pa_q <= mp;
      endcase
    end else if (cmd_i.div_take && cmd_i.sel == 3'd0) begin
      // numerator times dz for the second projection
      pa_q <= mp;
    end
    // capture quotient results
    if (cmd_i.div_take) begin
      unique case (cmd_i.sel)
        3'd0: begin
          n_q[0] <= 23'(v1x_q) + sat_q(quo_s);
          n_q[2] <= 23'(v2x_q) - sat_q(quo_s);
        end
        3'd1: begin
          n_q[1] <= 23'(v1z_q) + sat_q(quo_s);
          n_q[3] <= 23'(v2z_q) - sat_q(quo_s);
        end
        default: n_q[cmd_i.sel[1:0] - 2'd2] <= sat_q(quo_s);
      endcase
    end
  end

  assign sts_o.skip = skip_q;
  assign sts_o.coincident = coin_q;

  // results and partner update
  logic [19:0] fo [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dpec_pkg::NumDiscs; i++) partner_q[i] <= dpec_pkg::NoPartner;
    end else if (cmd_i.finish) begin
      partner_q[u_q] <= {1'b0, v_q};
      if (u_q != v_q) partner_q[v_q] <= {1'b0, u_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      collided_o <= 1'b0;
      repeat_o <= 1'b0;
      for (int i = 0; i < 4; i++) fo[i] <= in_data_i[88 + 20*i +: 20];
    end else if (cmd_i.sel == 3'd1) begin
      repeat_o <= rep_q;
    end else if (cmd_i.finish) begin
      collided_o <= 1'b1;
      for (int i = 0; i < 4; i++) fo[i] <= sat20(n_q[i]);
    end
  end
  assign vel_o = {fo[3], fo[2], fo[1], fo[0]};

endmodule
